### sv/ffa_pkg.sv
`timescale 1ns / 1ps

package ffa_pkg;

    localparam int OFS_W  = 16;
    localparam int STAT_W = 2;

    // default heap geometry
    localparam int HEAP_BYTES_DEF   = 65536;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int WORD_BYTES_DEF   = 8;

    // width of the constant operand of the shared multiplier
    localparam int MUL_B_W = 18;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_MEMORY = 2'd2;
    localparam logic [STAT_W-1:0] ST_NULL_FREE = 2'd3;

endpackage

### sv/ffa_ram.sv
`timescale 1ns / 1ps

module ffa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/first_fit_free_list_allocator_top.sv
// steps: error items answer from idle; free maps the offset to a slot and writes
//   the link; allocate rounds, walks blocks, splits if needed, relinks the list
// throughput: one item at a time; the list walk through the header memory,
//   with slot addresses from one shared multiplier, sets the allocate time
// reset: synchronous, active low; the init states then write the initial header
//   while busy is high. results are strobed for one cycle and cannot be stalled
`timescale 1ns / 1ps

module first_fit_free_list_allocator_top #(
    parameter int HEAP_BYTES   = ffa_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
    parameter int WORD_BYTES   = ffa_pkg::WORD_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_command,
    input  logic [ffa_pkg::OFS_W-1:0]  i_request_bytes,
    input  logic [ffa_pkg::OFS_W-1:0]  i_data_offset,
    output logic                       o_done,
    output logic [ffa_pkg::OFS_W-1:0]  o_result_offset,
    output logic [ffa_pkg::STAT_W-1:0] o_status
);

    localparam int OW      = ffa_pkg::OFS_W;
    localparam int DEPTH   = HEAP_BYTES / WORD_BYTES;
    localparam int AW      = $clog2(DEPTH);
    localparam int STEPS_W = $clog2(DEPTH + 1);
    localparam int MBW     = ffa_pkg::MUL_B_W;
    localparam int PW      = OW + MBW;

    // reciprocal constants, exact for every 16-bit dividend
    localparam int MW_SHIFT = OW + $clog2(WORD_BYTES);
    localparam longint unsigned MW_MUL =
        ((64'd1 << MW_SHIFT) + 64'(WORD_BYTES) - 64'd1) / 64'(WORD_BYTES);
    localparam int MD_SHIFT = OW + $clog2(DEPTH);
    localparam longint unsigned MD_MUL =
        ((64'd1 << MD_SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);

    localparam logic [OW-1:0] INIT_SIZE =
        OW'((HEAP_BYTES - HEADER_BYTES - WORD_BYTES) % 65536);
    localparam logic [AW-1:0] INIT_LINK_SLOT = AW'(1 % DEPTH);
    localparam logic [AW-1:0] LAST_SLOT      = AW'(DEPTH - 1);
    localparam logic [OW-1:0] HDR            = OW'(HEADER_BYTES);

    localparam logic [4:0] S_INIT0 = 5'd0;
    localparam logic [4:0] S_INIT1 = 5'd1;
    localparam logic [4:0] S_IDLE  = 5'd2;
    localparam logic [4:0] S_NE0   = 5'd3;
    localparam logic [4:0] S_NE1   = 5'd4;
    localparam logic [4:0] S_NE2   = 5'd5;
    localparam logic [4:0] S_VISIT = 5'd6;
    localparam logic [4:0] S_SL0   = 5'd7;
    localparam logic [4:0] S_SL1   = 5'd8;
    localparam logic [4:0] S_SL2   = 5'd9;
    localparam logic [4:0] S_SL3   = 5'd10;
    localparam logic [4:0] S_RDS   = 5'd11;
    localparam logic [4:0] S_RDL   = 5'd12;
    localparam logic [4:0] S_CHK   = 5'd13;
    localparam logic [4:0] S_SPW0  = 5'd14;
    localparam logic [4:0] S_SPW1  = 5'd15;
    localparam logic [4:0] S_SPW2  = 5'd16;
    localparam logic [4:0] S_RL    = 5'd17;
    localparam logic [4:0] S_FREE  = 5'd18;

    logic [4:0]         r_state, n_state;
    logic [4:0]         r_ret, n_ret;
    logic [OW-1:0]      r_req, n_req;
    logic [OW-1:0]      r_x, n_x;
    logic [PW-1:0]      r_prod;
    logic [OW-1:0]      r_q, n_q;
    logic [AW-1:0]      r_slot, n_slot;
    logic [OW-1:0]      r_cur, n_cur;
    logic [AW-1:0]      r_cur_slot, n_cur_slot;
    logic [AW-1:0]      r_prev_slot, n_prev_slot;
    logic               r_has_prev, n_has_prev;
    logic [STEPS_W-1:0] r_steps, n_steps;
    logic [OW:0]        r_need, n_need;
    logic [OW-1:0]      r_size, n_size;
    logic [OW-1:0]      r_link, n_link;
    logic [OW-1:0]      r_rest_size, n_rest_size;
    logic [OW-1:0]      r_rl_val, n_rl_val;
    logic [OW-1:0]      r_head, n_head;
    logic               r_head_valid, n_head_valid;
    logic               r_done, n_done;
    logic [OW-1:0]      r_res, n_res;
    logic [ffa_pkg::STAT_W-1:0] r_stat, n_stat;

    logic [OW-1:0]  mul_a;
    logic [MBW-1:0] mul_b;
    logic [PW-1:0]  mul_p;
    logic [OW-1:0]  q_w, q_d;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [OW-1:0] ram_wdata, ram_rdata;

    logic [OW-1:0] rem_w;
    logic          fit, split;
    logic [OW:0]   diff;
    logic [OW-1:0] rest, rest_data;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + AW'(1);
    endfunction

    ffa_ram #(
        .WIDTH (OW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign q_w = OW'(r_prod >> MW_SHIFT);
    assign q_d = OW'(r_prod >> MD_SHIFT);

    // shared multiplier: reciprocal divides, then multiply back for the remainder
    always_comb begin
        case (r_state)
            S_NE0: begin
                mul_a = r_req;
                mul_b = MBW'(MW_MUL);
            end
            S_NE1: begin
                mul_a = q_w;
                mul_b = MBW'(WORD_BYTES);
            end
            S_SL1: begin
                mul_a = q_w;
                mul_b = MBW'(MD_MUL);
            end
            S_SL2: begin
                mul_a = q_d;
                mul_b = MBW'(DEPTH);
            end
            default: begin
                mul_a = r_x;
                mul_b = MBW'(MW_MUL);
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign rem_w     = r_req - r_prod[OW-1:0];
    assign fit       = {1'b0, r_size} >= r_need;
    assign diff      = {1'b0, r_size} - r_need;
    assign rest      = r_cur + HDR + r_need[OW-1:0];
    assign rest_data = rest + HDR;
    assign split     = (diff >= (OW+1)'(HEADER_BYTES + WORD_BYTES)) && (rest_data != '0);

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_req        = r_req;
        n_x          = r_x;
        n_q          = r_q;
        n_slot       = r_slot;
        n_cur        = r_cur;
        n_cur_slot   = r_cur_slot;
        n_prev_slot  = r_prev_slot;
        n_has_prev   = r_has_prev;
        n_steps      = r_steps;
        n_need       = r_need;
        n_size       = r_size;
        n_link       = r_link;
        n_rest_size  = r_rest_size;
        n_rl_val     = r_rl_val;
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_done       = 1'b0;
        n_res        = r_res;
        n_stat       = r_stat;
        ram_we       = 1'b0;
        ram_waddr    = r_slot;
        ram_wdata    = r_rl_val;
        ram_raddr    = r_slot;

        case (r_state)
            S_INIT0: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = INIT_SIZE;
                n_state   = S_INIT1;
            end
            S_INIT1: begin
                ram_we    = 1'b1;
                ram_waddr = INIT_LINK_SLOT;
                ram_wdata = '0;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_req = i_request_bytes;
                    if (i_command == ffa_pkg::CMD_ALLOC) begin
                        if (i_request_bytes == '0) begin
                            n_done = 1'b1;
                            n_res  = '0;
                            n_stat = ffa_pkg::ST_BAD_SIZE;
                        end else begin
                            n_state = S_NE0;
                        end
                    end else if (i_data_offset == '0) begin
                        n_done = 1'b1;
                        n_res  = '0;
                        n_stat = ffa_pkg::ST_NULL_FREE;
                    end else begin
                        n_x     = i_data_offset - HDR;
                        n_ret   = S_FREE;
                        n_state = S_SL0;
                    end
                end
            end
            S_NE0: n_state = S_NE1;
            S_NE1: n_state = S_NE2;
            S_NE2: begin
                // round up to a word multiple, may reach 2^16
                n_need = (rem_w == '0) ? {1'b0, r_req}
                       : (OW+1)'(r_req) + (OW+1)'(WORD_BYTES) - (OW+1)'(rem_w);
                if (!r_head_valid) begin
                    n_done  = 1'b1;
                    n_res   = '0;
                    n_stat  = ffa_pkg::ST_NO_MEMORY;
                    n_state = S_IDLE;
                end else begin
                    n_cur      = r_head;
                    n_has_prev = 1'b0;
                    n_steps    = '0;
                    n_state    = S_VISIT;
                end
            end
            S_VISIT: begin
                // a cycle in the list ends the walk
                if (r_steps == STEPS_W'(DEPTH)) begin
                    n_done  = 1'b1;
                    n_res   = '0;
                    n_stat  = ffa_pkg::ST_NO_MEMORY;
                    n_state = S_IDLE;
                end else begin
                    n_x     = r_cur;
                    n_ret   = S_RDS;
                    n_state = S_SL0;
                end
            end
            S_SL0: n_state = S_SL1;
            S_SL1: begin
                n_q     = q_w;
                n_state = S_SL2;
            end
            S_SL2: n_state = S_SL3;
            S_SL3: begin
                n_slot  = AW'(r_q - r_prod[OW-1:0]);
                n_state = r_ret;
            end
            S_RDS: begin
                ram_raddr = r_slot;
                n_state   = S_RDL;
            end
            S_RDL: begin
                ram_raddr = next_slot(r_slot);
                n_size    = ram_rdata;
                n_state   = S_CHK;
            end
            S_CHK: begin
                n_link = ram_rdata;
                if (fit) begin
                    n_cur_slot = r_slot;
                    if (split) begin
                        n_x         = rest;
                        n_rest_size = r_size - HDR - r_need[OW-1:0];
                        n_rl_val    = rest_data;
                        n_ret       = S_SPW0;
                        n_state     = S_SL0;
                    end else begin
                        n_rl_val = ram_rdata;
                        n_state  = S_RL;
                    end
                end else if (ram_rdata == '0) begin
                    n_done  = 1'b1;
                    n_res   = '0;
                    n_stat  = ffa_pkg::ST_NO_MEMORY;
                    n_state = S_IDLE;
                end else begin
                    n_prev_slot = r_slot;
                    n_has_prev  = 1'b1;
                    n_cur       = ram_rdata - HDR;
                    n_steps     = r_steps + STEPS_W'(1);
                    n_state     = S_VISIT;
                end
            end
            S_SPW0: begin
                ram_we    = 1'b1;
                ram_waddr = r_slot;
                ram_wdata = r_rest_size;
                n_state   = S_SPW1;
            end
            S_SPW1: begin
                ram_we    = 1'b1;
                ram_waddr = next_slot(r_slot);
                ram_wdata = r_link;
                n_state   = S_SPW2;
            end
            S_SPW2: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur_slot;
                ram_wdata = r_need[OW-1:0];
                n_state   = S_RL;
            end
            S_RL: begin
                if (r_has_prev) begin
                    ram_we    = 1'b1;
                    ram_waddr = next_slot(r_prev_slot);
                    ram_wdata = r_rl_val;
                end else if (r_rl_val == '0) begin
                    n_head_valid = 1'b0;
                    n_head       = '0;
                end else begin
                    n_head_valid = 1'b1;
                    n_head       = r_rl_val - HDR;
                end
                n_done  = 1'b1;
                n_res   = r_cur + HDR;
                n_stat  = ffa_pkg::ST_OK;
                n_state = S_IDLE;
            end
            S_FREE: begin
                ram_we       = 1'b1;
                ram_waddr    = next_slot(r_slot);
                ram_wdata    = r_head_valid ? r_head + HDR : '0;
                n_head       = r_x;
                n_head_valid = 1'b1;
                n_done       = 1'b1;
                n_res        = '0;
                n_stat       = ffa_pkg::ST_OK;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT0;
            r_head       <= '0;
            r_head_valid <= 1'b1;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_head_valid <= n_head_valid;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret       <= n_ret;
        r_req       <= n_req;
        r_x         <= n_x;
        r_prod      <= mul_p;
        r_q         <= n_q;
        r_slot      <= n_slot;
        r_cur       <= n_cur;
        r_cur_slot  <= n_cur_slot;
        r_prev_slot <= n_prev_slot;
        r_has_prev  <= n_has_prev;
        r_steps     <= n_steps;
        r_need      <= n_need;
        r_size      <= n_size;
        r_link      <= n_link;
        r_rest_size <= n_rest_size;
        r_rl_val    <= n_rl_val;
        r_res       <= n_res;
        r_stat      <= n_stat;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_result_offset = r_res;
    assign o_status        = r_stat;

    a_bad_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == ffa_pkg::CMD_ALLOC) && (i_request_bytes == '0))
        |=> (o_done && (o_status == ffa_pkg::ST_BAD_SIZE)))
        else $error("zero request did not report bad size");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ffa_pkg::ST_OK)) |-> (o_result_offset == '0))
        else $error("error result carries an offset");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_steps < STEPS_W'(DEPTH)))
        else $error("list walk ran past the store depth");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_head_valid |-> (r_head == '0))
        else $error("empty list with nonzero head");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy || $past(r_state == S_IDLE))
        else $error("result strobed while still working");

endmodule
